### design/obs_pkg.sv
// ----------------------------------------------------------------------------
// obs_pkg: shared types and constants of the overlap box suppression block
// Field widths that do not vary, opcode and register codes, and the command
// and status words between controller and datapath.
// ----------------------------------------------------------------------------
package obs_pkg;

	localparam int CLASS_W = 10;
	localparam int SCORE_W = 16;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;

	localparam logic [CLASS_W-1:0] WANTED_CLASS_RST = 10'd2;

	typedef enum logic {
		OP_OFFER = 1'b0,
		OP_FLUSH = 1'b1
	} opcode_t;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_WANTED_CLASS = 1'b0,
		REG_NONE         = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic take;       // input channel ready
		logic rd_scan;    // read kept entry into the compare pipeline
		logic rd_flush;   // read kept entry for output
		logic append;     // close the scan, append the new box
		logic out_load;   // load output word from read data
		logic out_empty;  // load the empty-list output word
		logic out_last;   // last mark of the word being loaded
		logic clear_cnt;  // empty the kept list
	} dp_cmd_t;

	typedef struct packed {
		logic accept;     // input word taken this cycle
		logic flush;      // opcode of the input word is a flush
		logic match;      // class of the input word is the wanted one
		logic pipe_busy;  // compare pipeline holds entries
		logic out_free;   // output register is empty
	} dp_stat_t;

endpackage

### design/obs_in_if.sv
// ----------------------------------------------------------------------------
// obs_in_if: input box channel
// Valid/ready channel carrying one box offer or a flush command.
// ----------------------------------------------------------------------------
interface obs_in_if import obs_pkg::*; #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [CLASS_W-1:0]    box_class;
	logic [COORD_BITS-1:0] box_left;
	logic [COORD_BITS-1:0] box_top;
	logic [COORD_BITS-1:0] box_width;
	logic [COORD_BITS-1:0] box_height;
	logic [SCORE_W-1:0]    box_score;
	logic [COORD_BITS-1:0] crop_offset_x;
	logic [COORD_BITS-1:0] crop_offset_y;

	modport source (
		output valid, opcode, box_class, box_left, box_top, box_width, box_height,
		       box_score, crop_offset_x, crop_offset_y,
		input  ready
	);
	modport sink (
		input  valid, opcode, box_class, box_left, box_top, box_width, box_height,
		       box_score, crop_offset_x, crop_offset_y,
		output ready
	);
endinterface

### design/obs_out_if.sv
// ----------------------------------------------------------------------------
// obs_out_if: kept box output channel
// Valid/ready channel carrying one kept box of a flush.
// ----------------------------------------------------------------------------
interface obs_out_if import obs_pkg::*; #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS:0]   out_left;
	logic [COORD_BITS:0]   out_top;
	logic [COORD_BITS-1:0] out_width;
	logic [COORD_BITS-1:0] out_height;
	logic [SCORE_W-1:0]    out_score;
	logic                  out_valid;
	logic                  out_last;
	logic                  out_overflow;

	modport source (
		output valid, out_left, out_top, out_width, out_height, out_score,
		       out_valid, out_last, out_overflow,
		input  ready
	);
	modport sink (
		input  valid, out_left, out_top, out_width, out_height, out_score,
		       out_valid, out_last, out_overflow,
		output ready
	);
endinterface

### design/overlap_box_suppression_top.sv
// ----------------------------------------------------------------------------
// overlap_box_suppression_top: greedy overlap suppression of detection boxes
// Keeps a list of boxes of one class; of two boxes with IoU above one half it
// keeps the one with the higher score (the kept box on a tie), and emits the list on a flush.
// ----------------------------------------------------------------------------
// Usage:
//   boxes   : valid/ready input channel. opcode OP_OFFER offers one box, opcode
//             OP_FLUSH emits the kept list and empties it.
//   results : valid/ready output channel, one word per kept box on a flush,
//             out_last on the final word; a flush of an empty list gives one
//             word with out_valid low.
//   APB     : register 0 (byte address 0) holds the wanted class, reset 2.
//             Write it only while the block is idle.
// Timing:
//   An offered box of the wanted class is scanned against the kept list: the
//   controller reads one kept entry per cycle from the list memory into a
//   three-stage compare pipeline, drains it, then appends. Boxes of another
//   class are taken and dropped without a scan. A flush reads each kept box
//   from the list memory into the output register once that register is empty.
// Reset clears the kept list and the overflow flag, and empties the output register.
// When the receiver stalls, the output word holds and the flush waits; a new
// box is still taken once the last flush word sits in the output register.
// ----------------------------------------------------------------------------
module overlap_box_suppression_top import obs_pkg::*; #(
	parameter int MAX_KEPT   = 32,
	parameter int COORD_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	// data channels
	obs_in_if.sink             boxes,
	obs_out_if.source          results
);
	localparam int IDX_W = $clog2(MAX_KEPT);
	localparam int CNT_W = $clog2(MAX_KEPT + 1);

	logic [CLASS_W-1:0] wanted_class_q;
	logic               reg_hit;
	dp_cmd_t            cmd;
	dp_stat_t           stat;
	logic [IDX_W-1:0]   rd_idx;
	logic [CNT_W-1:0]   cnt;

	// only one register: decode the word index bit above the byte offset
	assign pready  = 1'b1;
	assign reg_hit = paddr[2] == logic'(REG_WANTED_CLASS);
	assign prdata  = reg_hit ? DATA_W'(wanted_class_q) : '0;

	// take the write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_class_q <= WANTED_CLASS_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			wanted_class_q <= pwdata[CLASS_W-1:0];
		end
	end

	// sequence scans and flushes
	obs_ctrl #(
		.MAX_KEPT (MAX_KEPT)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cnt    (cnt),
		.cmd    (cmd),
		.rd_idx (rd_idx)
	);

	// hold the list, compare, compact and drive the output word
	obs_dp #(
		.MAX_KEPT   (MAX_KEPT),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.wanted_class (wanted_class_q),
		.cmd          (cmd),
		.rd_idx       (rd_idx),
		.stat         (stat),
		.cnt          (cnt),
		.boxes        (boxes),
		.results      (results)
	);
endmodule

### design/obs_ram.sv
// ----------------------------------------------------------------------------
// obs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module obs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### design/obs_ctrl.sv
// ----------------------------------------------------------------------------
// obs_ctrl: sequencing of scan, append and flush
// Walks the kept list for each offered box of the wanted class and for each flush.
// ----------------------------------------------------------------------------
module obs_ctrl import obs_pkg::*; #(
	parameter int MAX_KEPT = 32,
	localparam int IDX_W   = $clog2(MAX_KEPT),
	localparam int CNT_W   = $clog2(MAX_KEPT + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_stat_t         stat,
	input  logic [CNT_W-1:0] cnt,
	output dp_cmd_t          cmd,
	output logic [IDX_W-1:0] rd_idx
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_APPEND,
		S_FL_RD,
		S_FL_LD
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] idx_q;
	logic             is_last;
	logic             more;

	assign is_last = (idx_q + CNT_W'(1)) == cnt;
	assign more    = idx_q < cnt;
	assign rd_idx  = idx_q[IDX_W-1:0];

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = 1'b1;
			end
			S_SCAN: begin
				cmd.rd_scan = more;
			end
			S_DRAIN: begin
			end
			S_APPEND: begin
				cmd.append = 1'b1;
			end
			S_FL_RD: begin
				cmd.out_empty = stat.out_free && (cnt == '0);
				cmd.rd_flush  = stat.out_free && (cnt != '0);
			end
			S_FL_LD: begin
				cmd.out_load  = 1'b1;
				cmd.out_last  = is_last;
				cmd.clear_cnt = is_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (stat.accept && stat.flush) begin
						state_q <= S_FL_RD;
					end else if (stat.accept && stat.match) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (more) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					state_q <= S_IDLE;
				end
				S_FL_RD: begin
					if (stat.out_free) begin
						state_q <= (cnt == '0) ? S_IDLE : S_FL_LD;
					end
				end
				S_FL_LD: begin
					if (is_last) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_FL_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

### design/obs_dp.sv
// ----------------------------------------------------------------------------
// obs_dp: box datapath
// New box registers, kept list memory, overlap compare pipeline, list
// compaction and the output register.
// ----------------------------------------------------------------------------
module obs_dp import obs_pkg::*; #(
	parameter int MAX_KEPT   = 32,
	parameter int COORD_BITS = 12,
	localparam int IDX_W     = $clog2(MAX_KEPT),
	localparam int CNT_W     = $clog2(MAX_KEPT + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CLASS_W-1:0] wanted_class,
	input  dp_cmd_t            cmd,
	input  logic [IDX_W-1:0]   rd_idx,
	output dp_stat_t           stat,
	output logic [CNT_W-1:0]   cnt,
	obs_in_if.sink             boxes,
	obs_out_if.source          results
);
	localparam int POS_W  = COORD_BITS + 1;
	localparam int SUM_W  = COORD_BITS + 2;
	localparam int AREA_W = 2 * COORD_BITS;
	localparam int TRI_W  = AREA_W + 2;
	localparam int ENT_W  = 2 * POS_W + 2 * COORD_BITS + SCORE_W;

	// new box
	logic [POS_W-1:0]      nl_q, nt_q;
	logic [COORD_BITS-1:0] nw_q, nh_q;
	logic [SCORE_W-1:0]    ns_q;
	logic [AREA_W-1:0]     area_a_q;

	// list control
	logic [CNT_W-1:0] cnt_q, w_q;
	logic             blocked_q, ovf_q, ovld_q;
	logic             v_s1, v_s2, v_s3;

	// memory
	logic [ENT_W-1:0] rd_data, wr_data, new_ent;
	logic             we, keep_wr, app_wr;

	// stage 1 fields
	logic [POS_W-1:0]      b_left, b_top;
	logic [COORD_BITS-1:0] b_w, b_h;
	logic [SUM_W-1:0]      a_r, a_b, b_r, b_b, a_l, a_t, b_l, b_t;
	logic [SUM_W-1:0]      x_hi, x_lo, y_hi, y_lo, dx_full, dy_full;
	logic                  ov;

	// stage 2 / 3
	logic [COORD_BITS-1:0] dx_s2, dy_s2;
	logic [ENT_W-1:0]      ent_s2, ent_s3;
	logic [AREA_W-1:0]     inter_s3, areab_s3;
	logic [TRI_W-1:0]      tri_inter, area_sum;
	logic [SCORE_W-1:0]    s3_score;
	logic                  heavy, wins, full;

	// output payload
	logic [POS_W-1:0]      o_left_q, o_top_q;
	logic [COORD_BITS-1:0] o_w_q, o_h_q;
	logic [SCORE_W-1:0]    o_s_q;
	logic                  o_v_q, o_last_q, o_ovf_q;

	assign boxes.ready    = cmd.take;
	assign stat.accept    = boxes.valid && cmd.take;
	assign stat.flush     = boxes.opcode == logic'(OP_FLUSH);
	assign stat.match     = boxes.box_class == wanted_class;
	assign stat.pipe_busy = v_s1 || v_s2 || v_s3;
	assign stat.out_free  = !ovld_q;
	assign cnt            = cnt_q;

	always_ff @(posedge clk) begin
		if (stat.accept) begin
			nl_q     <= POS_W'(boxes.box_left) + POS_W'(boxes.crop_offset_x);
			nt_q     <= POS_W'(boxes.box_top) + POS_W'(boxes.crop_offset_y);
			nw_q     <= boxes.box_width;
			nh_q     <= boxes.box_height;
			ns_q     <= boxes.box_score;
			area_a_q <= AREA_W'(boxes.box_width) * AREA_W'(boxes.box_height);
		end
	end

	assign new_ent = {nl_q, nt_q, nw_q, nh_q, ns_q};

	obs_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_KEPT)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (w_q[IDX_W-1:0]),
		.wdata (wr_data),
		.re    (cmd.rd_scan || cmd.rd_flush),
		.raddr (rd_idx),
		.rdata (rd_data)
	);

	// stage 1: edge tests and overlap extents against the read entry
	assign b_left = rd_data[ENT_W-1 -: POS_W];
	assign b_top  = rd_data[ENT_W-POS_W-1 -: POS_W];
	assign b_w    = rd_data[2*COORD_BITS+SCORE_W-1 -: COORD_BITS];
	assign b_h    = rd_data[COORD_BITS+SCORE_W-1 -: COORD_BITS];

	assign a_l = SUM_W'(nl_q);
	assign a_t = SUM_W'(nt_q);
	assign b_l = SUM_W'(b_left);
	assign b_t = SUM_W'(b_top);
	assign a_r = a_l + SUM_W'(nw_q);
	assign a_b = a_t + SUM_W'(nh_q);
	assign b_r = b_l + SUM_W'(b_w);
	assign b_b = b_t + SUM_W'(b_h);

	assign ov   = !((a_l > b_r) || (a_r < b_l) || (a_t > b_b) || (a_b < b_t));
	assign x_hi = (a_r < b_r) ? a_r : b_r;
	assign x_lo = (a_l > b_l) ? a_l : b_l;
	assign y_hi = (a_b < b_b) ? a_b : b_b;
	assign y_lo = (a_t > b_t) ? a_t : b_t;
	assign dx_full = x_hi - x_lo;
	assign dy_full = y_hi - y_lo;

	always_ff @(posedge clk) begin
		dx_s2    <= ov ? dx_full[COORD_BITS-1:0] : '0;
		dy_s2    <= ov ? dy_full[COORD_BITS-1:0] : '0;
		ent_s2   <= rd_data;
		inter_s3 <= AREA_W'(dx_s2) * AREA_W'(dy_s2);
		areab_s3 <= AREA_W'(ent_s2[2*COORD_BITS+SCORE_W-1 -: COORD_BITS])
		          * AREA_W'(ent_s2[COORD_BITS+SCORE_W-1 -: COORD_BITS]);
		ent_s3   <= ent_s2;
	end

	// stage 3: IoU above one half, score decision, compaction write
	assign tri_inter = (TRI_W'(inter_s3) << 1) + TRI_W'(inter_s3);
	assign area_sum  = TRI_W'(area_a_q) + TRI_W'(areab_s3);
	assign heavy     = tri_inter > area_sum;
	assign s3_score  = ent_s3[SCORE_W-1:0];
	assign wins      = ns_q > s3_score;
	assign keep_wr   = v_s3 && !(heavy && wins);
	assign full      = w_q == CNT_W'(MAX_KEPT);
	assign app_wr    = cmd.append && !blocked_q && !full;
	assign we        = keep_wr || app_wr;
	assign wr_data   = app_wr ? new_ent : ent_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			w_q       <= '0;
			cnt_q     <= '0;
			blocked_q <= 1'b0;
			ovf_q     <= 1'b0;
			ovld_q    <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_scan;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (stat.accept) begin
				w_q       <= '0;
				blocked_q <= 1'b0;
			end else begin
				if (keep_wr) begin
					w_q <= w_q + CNT_W'(1);
				end
				if (v_s3 && heavy) begin
					blocked_q <= !wins;
				end
			end
			if (cmd.append) begin
				cnt_q <= app_wr ? w_q + CNT_W'(1) : w_q;
				if (!blocked_q && full) begin
					ovf_q <= 1'b1;
				end
			end else if (cmd.clear_cnt) begin
				cnt_q <= '0;
			end
			if (cmd.out_load || cmd.out_empty) begin
				ovld_q <= 1'b1;
			end else if (results.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_left_q <= rd_data[ENT_W-1 -: POS_W];
			o_top_q  <= rd_data[ENT_W-POS_W-1 -: POS_W];
			o_w_q    <= rd_data[2*COORD_BITS+SCORE_W-1 -: COORD_BITS];
			o_h_q    <= rd_data[COORD_BITS+SCORE_W-1 -: COORD_BITS];
			o_s_q    <= rd_data[SCORE_W-1:0];
			o_v_q    <= 1'b1;
			o_last_q <= cmd.out_last;
			o_ovf_q  <= ovf_q;
		end else if (cmd.out_empty) begin
			o_left_q <= '0;
			o_top_q  <= '0;
			o_w_q    <= '0;
			o_h_q    <= '0;
			o_s_q    <= '0;
			o_v_q    <= 1'b0;
			o_last_q <= 1'b1;
			o_ovf_q  <= ovf_q;
		end
	end

	assign results.valid        = ovld_q;
	assign results.out_left     = o_left_q;
	assign results.out_top      = o_top_q;
	assign results.out_width    = o_w_q;
	assign results.out_height   = o_h_q;
	assign results.out_score    = o_s_q;
	assign results.out_valid    = o_v_q;
	assign results.out_last     = o_last_q;
	assign results.out_overflow = o_ovf_q;
endmodule
